// File: hw/rtl/rbnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbnh_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned HALF_W  = 31;
    localparam int unsigned DIST_W  = 31;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned DIFF_W  = COORD_W + 2;
    localparam int unsigned PROD_W  = 2 * COORD_W;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned SHIFT_W = PROD_W - FRAC_W;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam int unsigned S_TDATA_W = 200;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_DIR_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_DIR_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_DIR_Z = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RANGE = 3'd6;

    localparam logic [DIST_W-1:0] MAX_RANGE_RESET = {DIST_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
    } t_span;

    function automatic logic signed [COORD_W-1:0] sat_diff(
        input logic signed [DIFF_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v[DIFF_W-1:COORD_W-1] == '0 || v[DIFF_W-1:COORD_W-1] == '1) begin
            r = v[COORD_W-1:0];
        end else if (v[DIFF_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_shift(
        input logic signed [SHIFT_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v[SHIFT_W-1:COORD_W-1] == '0 || v[SHIFT_W-1:COORD_W-1] == '1) begin
            r = v[COORD_W-1:0];
        end else if (v[SHIFT_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rbnh_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module rbnh_axis (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [rbnh_pkg::COORD_W-1:0]  i_center,
    input  wire logic        [rbnh_pkg::HALF_W-1:0]   i_half,
    input  wire logic signed [rbnh_pkg::COORD_W-1:0]  i_origin,
    input  wire logic signed [rbnh_pkg::COORD_W-1:0]  i_inv_dir,
    output rbnh_pkg::t_span                           o_span
);

    logic signed [rbnh_pkg::DIFF_W-1:0]  n_d0, n_d1;
    logic signed [rbnh_pkg::COORD_W-1:0] r_d0, r_d1;
    logic signed [rbnh_pkg::PROD_W-1:0]  r_p0, r_p1;
    logic signed [rbnh_pkg::COORD_W-1:0] n_t0, n_t1;
    rbnh_pkg::t_span                     r_span;

    always_comb begin
        n_d0 = $signed({{2{i_center[rbnh_pkg::COORD_W-1]}}, i_center})
             - $signed({3'b000, i_half})
             - $signed({{2{i_origin[rbnh_pkg::COORD_W-1]}}, i_origin});
        n_d1 = $signed({{2{i_center[rbnh_pkg::COORD_W-1]}}, i_center})
             + $signed({3'b000, i_half})
             - $signed({{2{i_origin[rbnh_pkg::COORD_W-1]}}, i_origin});
        n_t0 = rbnh_pkg::sat_shift(r_p0[rbnh_pkg::PROD_W-1:rbnh_pkg::FRAC_W]);
        n_t1 = rbnh_pkg::sat_shift(r_p1[rbnh_pkg::PROD_W-1:rbnh_pkg::FRAC_W]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0 <= rbnh_pkg::sat_diff(n_d0);
            r_d1 <= rbnh_pkg::sat_diff(n_d1);
            r_p0 <= r_d0 * i_inv_dir;
            r_p1 <= r_d1 * i_inv_dir;
            if (n_t0 < n_t1) begin
                r_span.lo <= n_t0;
                r_span.hi <= n_t1;
            end else begin
                r_span.lo <= n_t1;
                r_span.hi <= n_t0;
            end
        end
    end

    assign o_span = r_span;

endmodule

`default_nettype wire

// File: hw/rtl/ray_box_nearest_hit_unit.sv
// After the box marked last is accepted, its result passes the input register, the slab difference,
// product and span registers, the near/far register and the output register. Throughput: one box per cycle
// while not stalled; the slab multipliers are fully pipelined. Input stalls only when a second result
// is ready to enter the output register while the previous result beat has not been taken.
// Reset (synchronous, active low): pipeline empty, origin and reciprocal registers to zero,
// max_range and best distance to all ones, no hit recorded.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_nearest_hit_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [rbnh_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire logic [rbnh_pkg::COORD_W-1:0]           i_cfg_data,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, box_index, pad
    input  wire logic [rbnh_pkg::S_TDATA_W-1:0]         s_axis_tdata,
    // last_box
    input  wire logic                                   s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // hit_index, hit_distance, pad
    output logic [rbnh_pkg::M_TDATA_W-1:0]              m_axis_tdata,
    // hit_found
    output logic                                        m_axis_tuser
);

    localparam int unsigned CW = rbnh_pkg::COORD_W;
    localparam int unsigned HW = rbnh_pkg::HALF_W;
    localparam int unsigned IW = rbnh_pkg::INDEX_W;
    localparam int unsigned DW = rbnh_pkg::DIST_W;

    logic signed [CW-1:0] r_origin [3];
    logic signed [CW-1:0] r_inv    [3];
    logic [DW-1:0]        r_max_range;

    logic                 r_v0, r_v1, r_v2, r_v3, r_v4;
    logic signed [CW-1:0] r_center [3];
    logic [HW-1:0]        r_half   [3];
    logic [IW-1:0]        r_idx0, r_idx1, r_idx2, r_idx3, r_idx4;
    logic                 r_last0, r_last1, r_last2, r_last3, r_last4;

    rbnh_pkg::t_span      w_span [3];
    logic signed [CW-1:0] n_near, n_far, n_m;
    logic signed [CW-1:0] r_near4;
    logic                 r_pre4;

    logic                 r_any;
    logic [IW-1:0]        r_best_idx;
    logic [DW-1:0]        r_best;
    logic                 n_hit, n_any;
    logic [IW-1:0]        n_best_idx;
    logic [DW-1:0]        n_best;

    logic                 r_out_valid, r_out_found;
    logic [IW-1:0]        r_out_idx;
    logic [DW-1:0]        r_out_dist;

    logic                 w_stall, w_en, w_emit;

    assign w_stall = r_v4 && r_last4 && r_out_valid && !m_axis_tready;
    assign w_en    = !w_stall;
    assign w_emit  = w_en && r_v4 && r_last4;
    assign s_axis_tready = w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_origin[a] <= '0;
                r_inv[a]    <= '0;
            end
            r_max_range <= rbnh_pkg::MAX_RANGE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rbnh_pkg::CFG_ORIGIN_X:  r_origin[0] <= i_cfg_data;
                rbnh_pkg::CFG_ORIGIN_Y:  r_origin[1] <= i_cfg_data;
                rbnh_pkg::CFG_ORIGIN_Z:  r_origin[2] <= i_cfg_data;
                rbnh_pkg::CFG_INV_DIR_X: r_inv[0]    <= i_cfg_data;
                rbnh_pkg::CFG_INV_DIR_Y: r_inv[1]    <= i_cfg_data;
                rbnh_pkg::CFG_INV_DIR_Z: r_inv[2]    <= i_cfg_data;
                rbnh_pkg::CFG_MAX_RANGE: r_max_range <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // input register and delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_center[0] <= s_axis_tdata[31:0];
            r_center[1] <= s_axis_tdata[63:32];
            r_center[2] <= s_axis_tdata[95:64];
            r_half[0]   <= s_axis_tdata[126:96];
            r_half[1]   <= s_axis_tdata[157:127];
            r_half[2]   <= s_axis_tdata[188:158];
            r_idx0      <= s_axis_tdata[198:189];
            r_last0     <= s_axis_tlast;
            r_idx1      <= r_idx0;
            r_idx2      <= r_idx1;
            r_idx3      <= r_idx2;
            r_idx4      <= r_idx3;
            r_last1     <= r_last0;
            r_last2     <= r_last1;
            r_last3     <= r_last2;
            r_last4     <= r_last3;
            r_near4     <= n_near;
            r_pre4      <= (n_far >= n_near) && (n_near > 0);
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbnh_axis u_axis (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_center  (r_center[a]),
            .i_half    (r_half[a]),
            .i_origin  (r_origin[a]),
            .i_inv_dir (r_inv[a]),
            .o_span    (w_span[a])
        );
    end

    // combine axes: largest entry, smallest exit
    always_comb begin
        n_m    = (w_span[1].lo > w_span[0].lo) ? w_span[1].lo : w_span[0].lo;
        n_near = (w_span[2].lo > n_m) ? w_span[2].lo : n_m;
        n_far  = (w_span[1].hi < w_span[0].hi) ? w_span[1].hi : w_span[0].hi;
        n_far  = (w_span[2].hi < n_far) ? w_span[2].hi : n_far;
    end

    // running nearest hit
    always_comb begin
        n_hit      = r_pre4 && (r_near4 < $signed({1'b0, r_best}));
        n_any      = r_any;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        if (n_hit) begin
            n_any      = 1'b1;
            n_best_idx = r_idx4;
            n_best     = r_near4[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any      <= 1'b0;
            r_best_idx <= '0;
            r_best     <= rbnh_pkg::MAX_RANGE_RESET;
        end else if (w_en && r_v4) begin
            if (r_last4) begin
                r_any      <= 1'b0;
                r_best_idx <= '0;
                r_best     <= r_max_range;
            end else begin
                r_any      <= n_any;
                r_best_idx <= n_best_idx;
                r_best     <= n_best;
            end
        end else if (i_cfg_we && i_cfg_addr == rbnh_pkg::CFG_MAX_RANGE && !r_any) begin
            r_best <= i_cfg_data[DW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_found <= n_any;
            r_out_idx   <= n_best_idx;
            r_out_dist  <= n_best;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {{(rbnh_pkg::M_TDATA_W - IW - DW){1'b0}}, r_out_dist, r_out_idx};

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> (r_v4 && r_last4))
        else $error("stalled result lost from last stage");

    a_hit_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_best != '0))
        else $error("recorded hit at zero distance");

    a_no_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_best_idx == '0))
        else $error("index kept without a hit");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (!r_any && r_out_valid))
        else $error("query state not cleared after result");

    a_miss_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0))
        else $error("miss result carries an index");

endmodule

`default_nettype wire

// File: dv/nearest_hit_checker.sv
`timescale 1ns / 1ps

module nearest_hit_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rbnh_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [rbnh_pkg::COORD_W-1:0]       i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, box_index, pad
    input  wire logic [rbnh_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // last_box
    input  wire logic                               s_axis_tlast,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // hit_index, hit_distance, pad
    input  wire logic [rbnh_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // hit_found
    input  wire logic                               m_axis_tuser,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_LO = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic                               found;
        logic [rbnh_pkg::INDEX_W-1:0]       index;
        logic [rbnh_pkg::DIST_W-1:0]        distance;
    } t_hit;

    t_hit               pending_hits[$];
    t_hit               want;

    longint             ray_org [3];
    longint             ray_inv [3];
    logic [rbnh_pkg::DIST_W-1:0]  range_lim;
    logic [rbnh_pkg::DIST_W-1:0]  best_dist;
    logic [rbnh_pkg::INDEX_W-1:0] best_idx;
    logic               got_hit;

    longint             c_val;
    longint             h_val;
    longint             t0;
    longint             t1;
    longint             t_near;
    longint             t_far;
    longint             limit;
    int                 ax;

    function automatic longint clamp32(input longint v);
        if (v > S32_HI) begin
            return S32_HI;
        end
        if (v < S32_LO) begin
            return S32_LO;
        end
        return v;
    endfunction

    function automatic longint slab_time(input longint diff, input longint inv);
        return clamp32((clamp32(diff) * inv) >>> rbnh_pkg::FRAC_W);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (ax = 0; ax < 3; ax++) begin
                ray_org[ax] = 0;
                ray_inv[ax] = 0;
            end
            range_lim = rbnh_pkg::MAX_RANGE_RESET;
            best_dist = rbnh_pkg::MAX_RANGE_RESET;
            best_idx = '0;
            got_hit = 1'b0;
            o_fail_count = 0;
            pending_hits.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rbnh_pkg::CFG_ORIGIN_X:  ray_org[0] = longint'($signed(i_cfg_data));
                    rbnh_pkg::CFG_ORIGIN_Y:  ray_org[1] = longint'($signed(i_cfg_data));
                    rbnh_pkg::CFG_ORIGIN_Z:  ray_org[2] = longint'($signed(i_cfg_data));
                    rbnh_pkg::CFG_INV_DIR_X: ray_inv[0] = longint'($signed(i_cfg_data));
                    rbnh_pkg::CFG_INV_DIR_Y: ray_inv[1] = longint'($signed(i_cfg_data));
                    rbnh_pkg::CFG_INV_DIR_Z: ray_inv[2] = longint'($signed(i_cfg_data));
                    rbnh_pkg::CFG_MAX_RANGE: begin
                        range_lim = i_cfg_data[rbnh_pkg::DIST_W-1:0];
                        if (!got_hit) begin
                            best_dist = range_lim;
                        end
                    end
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_hits.size() == 0) begin
                    $error("result beat with no query waiting");
                    o_fail_count++;
                end else begin
                    want = pending_hits.pop_front();
                    if (m_axis_tuser !== want.found) begin
                        $error("hit_found: expected %0d, got %0d", want.found, m_axis_tuser);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[rbnh_pkg::INDEX_W-1:0] !== want.index) begin
                        $error("hit_index: expected %0d, got %0d",
                               want.index, m_axis_tdata[rbnh_pkg::INDEX_W-1:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[rbnh_pkg::INDEX_W +: rbnh_pkg::DIST_W]
                            !== want.distance) begin
                        $error("hit_distance: expected 0x%08h, got 0x%08h",
                               want.distance,
                               m_axis_tdata[rbnh_pkg::INDEX_W +: rbnh_pkg::DIST_W]);
                        o_fail_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                for (ax = 0; ax < 3; ax++) begin
                    c_val = longint'($signed(
                        s_axis_tdata[ax*rbnh_pkg::COORD_W +: rbnh_pkg::COORD_W]));
                    h_val = longint'(s_axis_tdata[3*rbnh_pkg::COORD_W
                        + ax*rbnh_pkg::HALF_W +: rbnh_pkg::HALF_W]);
                    t0 = slab_time(c_val - h_val - ray_org[ax], ray_inv[ax]);
                    t1 = slab_time(c_val + h_val - ray_org[ax], ray_inv[ax]);
                    if (t1 < t0) begin
                        c_val = t0;
                        t0 = t1;
                        t1 = c_val;
                    end
                    if (ax == 0 || t0 > t_near) begin
                        t_near = t0;
                    end
                    if (ax == 0 || t1 < t_far) begin
                        t_far = t1;
                    end
                end
                limit = got_hit ? longint'(best_dist) : longint'(range_lim);
                if (t_far >= t_near && t_near > 0 && t_near < limit) begin
                    best_dist = t_near[rbnh_pkg::DIST_W-1:0];
                    best_idx = s_axis_tdata[3*rbnh_pkg::COORD_W + 3*rbnh_pkg::HALF_W
                                            +: rbnh_pkg::INDEX_W];
                    got_hit = 1'b1;
                end
                if (s_axis_tlast) begin
                    want.found = got_hit;
                    want.index = got_hit ? best_idx : '0;
                    want.distance = got_hit ? best_dist : range_lim;
                    pending_hits.push_back(want);
                    got_hit = 1'b0;
                    best_idx = '0;
                    best_dist = range_lim;
                end
            end
        end
        o_pending = pending_hits.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int     PIPE_FLUSH = 10;
    localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_LO = -64'sh0000_0000_8000_0000;
    localparam longint ONE_Q = 64'sd65536;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [rbnh_pkg::CFG_ADDR_W-1:0]    i_cfg_addr;
    logic [rbnh_pkg::COORD_W-1:0]       i_cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [rbnh_pkg::S_TDATA_W-1:0]     s_axis_tdata;
    logic                               s_axis_tlast;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [rbnh_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic                               m_axis_tuser;

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;
    int boxes_sent;
    int queries;
    int ray_settings;

    logic signed [rbnh_pkg::COORD_W-1:0] ray_org [3];
    logic signed [rbnh_pkg::COORD_W-1:0] ray_inv [3];
    logic [rbnh_pkg::DIST_W-1:0]         ray_rng;
    logic signed [rbnh_pkg::COORD_W-1:0] bx_c [3];
    logic [rbnh_pkg::HALF_W-1:0]         bx_h [3];

    ray_box_nearest_hit_unit i_dut (.*);

    nearest_hit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic signed [rbnh_pkg::COORD_W-1:0] fit_s32(input longint v);
        if (v > S32_HI) begin
            return S32_HI[rbnh_pkg::COORD_W-1:0];
        end
        if (v < S32_LO) begin
            return S32_LO[rbnh_pkg::COORD_W-1:0];
        end
        return v[rbnh_pkg::COORD_W-1:0];
    endfunction

    function automatic logic signed [rbnh_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            default: return $signed($urandom_range(200 * 65536)) - 100 * 65536;
        endcase
    endfunction

    function automatic logic signed [rbnh_pkg::COORD_W-1:0] rand_inv();
        logic signed [rbnh_pkg::COORD_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = 32'sh7FFF_FFFF;
            2: v = 32'sh8000_0000;
            3: v = $urandom;
            default: begin
                v = 32'sd1 <<< $urandom_range(12, 20);
                if ($urandom_range(1)) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [rbnh_pkg::DIST_W-1:0] rand_range();
        case ($urandom_range(9))
            0: return '0;
            1: return rbnh_pkg::MAX_RANGE_RESET;
            2: return 31'($urandom);
            default: return 31'($urandom_range(150 * 65536, 1));
        endcase
    endfunction

    task automatic write_reg(input logic [rbnh_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [rbnh_pkg::COORD_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_ray();
        write_reg(rbnh_pkg::CFG_ORIGIN_X, ray_org[0]);
        write_reg(rbnh_pkg::CFG_ORIGIN_Y, ray_org[1]);
        write_reg(rbnh_pkg::CFG_ORIGIN_Z, ray_org[2]);
        write_reg(rbnh_pkg::CFG_INV_DIR_X, ray_inv[0]);
        write_reg(rbnh_pkg::CFG_INV_DIR_Y, ray_inv[1]);
        write_reg(rbnh_pkg::CFG_INV_DIR_Z, ray_inv[2]);
        write_reg(rbnh_pkg::CFG_MAX_RANGE, {1'b0, ray_rng});
        i_cfg_we <= 1'b0;
        ray_settings++;
    endtask

    task automatic set_range(input logic [rbnh_pkg::DIST_W-1:0] rng);
        ray_rng = rng;
        write_reg(rbnh_pkg::CFG_MAX_RANGE, {1'b0, rng});
        i_cfg_we <= 1'b0;
    endtask

    // drop valid, wait out all results and the pipeline tail
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (PIPE_FLUSH) @(posedge i_clk);
    endtask

    task automatic push_box(
        input logic signed [rbnh_pkg::COORD_W-1:0] cx,
        input logic signed [rbnh_pkg::COORD_W-1:0] cy,
        input logic signed [rbnh_pkg::COORD_W-1:0] cz,
        input logic [rbnh_pkg::HALF_W-1:0]         hx,
        input logic [rbnh_pkg::HALF_W-1:0]         hy,
        input logic [rbnh_pkg::HALF_W-1:0]         hz,
        input logic [rbnh_pkg::INDEX_W-1:0]        idx,
        input logic                                last
    );
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, idx, hz, hy, hx, cz, cy, cx};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        boxes_sent++;
        if (last) begin
            queries++;
        end
    endtask

    task automatic push_cur(input logic [rbnh_pkg::INDEX_W-1:0] idx, input logic last);
        push_box(bx_c[0], bx_c[1], bx_c[2], bx_h[0], bx_h[1], bx_h[2], idx, last);
    endtask

    // place a box around the point at distance t_q along the current ray
    task automatic gen_on_ray(input longint t_q, input int hmax);
        int a;
        for (a = 0; a < 3; a++) begin
            if (ray_inv[a] == 0) begin
                bx_c[a] = fit_s32(longint'(ray_org[a])
                                  + longint'($urandom_range(2 * hmax)) - longint'(hmax));
            end else begin
                bx_c[a] = fit_s32(longint'(ray_org[a]) + (t_q * ONE_Q) / longint'(ray_inv[a]));
            end
            bx_h[a] = 31'($urandom_range(hmax));
        end
    endtask

    task automatic run_queries(input int n);
        int len;
        int k;
        int first;
        logic last;
        first = boxes_sent;
        while (boxes_sent - first < n) begin
            len = $urandom_range(10, 1);
            for (k = 0; k < len; k++) begin
                last = (k == len - 1);
                if (k > 0 && k == len / 2 && $urandom_range(11) == 0) begin
                    settle();
                    set_range(rand_range());
                end
                case ($urandom_range(9))
                    0, 1: push_box($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                                   31'($urandom), 10'($urandom), last);
                    2: push_cur(10'($urandom), last);
                    default: begin
                        gen_on_ray((longint'($urandom_range(240)) - 20) * ONE_Q
                                   + longint'($urandom_range(65535)), $urandom_range(8 * 65536));
                        push_cur(10'($urandom), last);
                    end
                endcase
            end
        end
    endtask

    initial begin
        int ph;
        int r;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        send_idle = 0;
        recv_idle = 0;
        boxes_sent = 0;
        queries = 0;
        ray_settings = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero reciprocals never hit, extreme fields
        push_box(32'sh8000_0000, 32'sh7FFF_FFFF, '0, 31'h7FFF_FFFF, '0, 31'h7FFF_FFFF,
                 10'd1023, 1'b1);
        settle();

        ray_org[0] = 32'sd1 <<< 16;
        ray_org[1] = 32'sd2 <<< 16;
        ray_org[2] = -(32'sd3 <<< 16);
        ray_inv[0] = 32'sd1 <<< 16;
        ray_inv[1] = 32'sd1 <<< 17;
        ray_inv[2] = -(32'sd1 <<< 16);
        ray_rng = 31'(50 * 65536);
        load_ray();

        // equal distance keeps the earlier box, beyond range is ignored
        gen_on_ray(10 * ONE_Q, 65536);
        push_cur(10'd5, 1'b0);
        push_cur(10'd6, 1'b0);
        gen_on_ray(20 * ONE_Q, 65536);
        push_cur(10'd7, 1'b0);
        gen_on_ray(60 * ONE_Q, 65536);
        push_cur(10'd8, 1'b1);
        settle();

        // range change inside a query, before and after a hit
        set_range(31'(8 * 65536));
        gen_on_ray(10 * ONE_Q, 0);
        push_cur(10'd1, 1'b0);
        settle();
        set_range(31'(40 * 65536));
        gen_on_ray(12 * ONE_Q, 65536);
        push_cur(10'd2, 1'b1);
        gen_on_ray(3 * ONE_Q, 0);
        push_cur(10'd3, 1'b0);
        settle();
        set_range(31'(65536));
        gen_on_ray(2 * ONE_Q, 0);
        push_cur(10'd4, 1'b1);
        gen_on_ray(2 * ONE_Q, 0);
        push_cur(10'd9, 1'b1);
        settle();

        // saturated reciprocals and extreme origins
        ray_org[0] = 32'sh7FFF_FFFF;
        ray_org[1] = 32'sh8000_0000;
        ray_org[2] = '0;
        ray_inv[0] = 32'sh7FFF_FFFF;
        ray_inv[1] = 32'sh8000_0000;
        ray_inv[2] = '0;
        ray_rng = rbnh_pkg::MAX_RANGE_RESET;
        load_ray();
        push_box(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1234_5678, 31'h7FFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10'd0, 1'b0);
        push_box(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, '0, '0, '0,
                 10'd1023, 1'b1);
        settle();

        // one axis with zero reciprocal, then zero range
        ray_org[0] = '0;
        ray_org[1] = '0;
        ray_org[2] = '0;
        ray_inv[0] = 32'sd1 <<< 16;
        ray_inv[1] = '0;
        ray_inv[2] = 32'sd1 <<< 16;
        load_ray();
        gen_on_ray(5 * ONE_Q, 65536);
        push_cur(10'd10, 1'b1);
        settle();
        set_range('0);
        push_cur(10'd11, 1'b1);
        settle();

        for (ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 19 : (ph == 1) ? 50 : 0;
            recv_idle = (ph == 0) ? 50 : (ph == 1) ? 19 : 0;
            for (r = 0; r < 5; r++) begin
                settle();
                for (int a = 0; a < 3; a++) begin
                    ray_org[a] = rand_coord();
                    ray_inv[a] = rand_inv();
                end
                ray_rng = rand_range();
                load_ray();
                run_queries(100);
            end
        end
        settle();

        $display("Checked %0d boxes in %0d queries over %0d ray settings,",
                 boxes_sent, queries, ray_settings);
        $display("with input and output stalls swapped between phases, then back to back.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
